[hw/rtl/sed_pkg.sv]
package sed_pkg;

    localparam int PIX_W          = 8;
    localparam int MAG_W          = 11;
    localparam int SUM_W          = 10;
    localparam int FRAME_WIDTH_W  = 11;
    localparam int FRAME_HEIGHT_W = 16;
    localparam int ROW_W          = FRAME_HEIGHT_W + 1;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 16;

    localparam int MAX_WIDTH_DEF  = 1024;

    localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
    localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 16'd480;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = 3;
    localparam int FIFO_CNT_W = 4;
    localparam int OCC_W      = 5;

    // Window indexed as [row][col]; row 0 is the upper row, col 2 the newest column.
    typedef logic [2:0][2:0][PIX_W-1:0] window_t;

    typedef struct packed {
        logic emit_a;
        logic emit_b;
        logic run_end_a;
        logic frame_end_b;
    } emit_t;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic             run_end;
        logic             frame_end;
    } result_t;

    function automatic logic [SUM_W-1:0] wsum3(
        input logic [PIX_W-1:0] a,
        input logic [PIX_W-1:0] b,
        input logic [PIX_W-1:0] c
    );
        wsum3 = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
    endfunction

    function automatic logic [SUM_W-1:0] absdiff(
        input logic [SUM_W-1:0] a,
        input logic [SUM_W-1:0] b
    );
        absdiff = (a >= b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [1:0] emit_count(input emit_t e);
        emit_count = {1'b0, e.emit_a} + {1'b0, e.emit_b};
    endfunction

endpackage

[hw/rtl/sobel_edge_magnitude_core.sv]
// 3x3 Sobel edge detector with |Gx|+|Gy| magnitude over a raster pixel stream. It takes one
// pixel per unstalled clock; pixel (r,c) gives the result for (r-1,c-1) through the memory,
// window and sum registers into the 8-beat queue, and the last column of a row adds the
// result for (r-1,W-1), so a row of W pixels gives W results (none for row 0) and the
// output side, one beat per unstalled clock, sets the pace at two results per last-column
// pixel. The two line stores share one MAX_WIDTH-deep memory, read when a pixel is taken
// and written back in the next cycle; a pixel at the same column as the one before it
// (width 1) gets the written-back word forwarded. A fill mark makes entries never written
// since reset read as zero, so there is no clearing pass after reset. in_stall rises only
// when the queue plus results still in flight could run out of room. After the frame, feed
// W more beats (drain may be set) to flush the last row; frame_end marks pixel (H-1,W-1).
module sobel_edge_magnitude_core #(
    parameter int MAX_WIDTH = sed_pkg::MAX_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [sed_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sed_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [sed_pkg::PIX_W-1:0]        pixel,
    input  logic                             drain,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [sed_pkg::MAG_W-1:0]        magnitude,
    output logic                             run_end,
    output logic                             frame_end
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int FILL_W = COL_W + 1;
    localparam int CW     = (FILL_W > sed_pkg::FRAME_WIDTH_W) ? FILL_W : sed_pkg::FRAME_WIDTH_W;
    localparam int WORD_W = 2 * sed_pkg::PIX_W;

    // Configuration
    logic [sed_pkg::FRAME_WIDTH_W-1:0]  frame_width_reg;
    logic [sed_pkg::FRAME_HEIGHT_W-1:0] frame_height_reg;

    // Raster position
    logic [COL_W-1:0]          col_reg;
    logic [COL_W-1:0]          col_next;
    logic [sed_pkg::ROW_W-1:0] row_reg;
    logic [sed_pkg::ROW_W-1:0] row_next;
    logic [FILL_W-1:0]         fill_reg;
    logic [FILL_W-1:0]         fill_next;

    // Accept stage
    logic                               accept;
    logic [CW-1:0]                      w_raw;
    logic [CW-1:0]                      w_eff;
    logic [sed_pkg::FRAME_HEIGHT_W-1:0] h_eff;
    logic                               drain_row;
    logic                               last_col;
    logic                               row0;
    logic                               col0;
    logic [sed_pkg::PIX_W-1:0]          px_in;
    sed_pkg::emit_t                     emit_in;

    // Line memory: upper row in the high byte, middle row in the low byte.
    logic [WORD_W-1:0] line_mem [MAX_WIDTH];

    // Memory stage
    logic                      s1_valid_reg;
    logic [COL_W-1:0]          s1_col_reg;
    logic [sed_pkg::PIX_W-1:0] s1_px_reg;
    logic                      s1_row0_reg;
    logic                      s1_col0_reg;
    sed_pkg::emit_t            s1_emit_reg;
    logic [WORD_W-1:0]         rd_word_reg;
    logic                      rd_zero_reg;
    logic                      fwd_hit_reg;
    logic [WORD_W-1:0]         fwd_word_reg;
    logic [WORD_W-1:0]         rd_word;
    logic [sed_pkg::PIX_W-1:0] up_rd;
    logic [sed_pkg::PIX_W-1:0] mid_rd;
    logic [WORD_W-1:0]         wr_word;

    // Window stage
    sed_pkg::window_t window_reg;
    sed_pkg::window_t window_next;
    sed_pkg::emit_t   w_emit_reg;

    // Sobel and result queue
    logic                           push_a;
    logic                           push_b;
    sed_pkg::result_t               res_a;
    sed_pkg::result_t               res_b;
    logic [1:0]                     pend_sum;
    sed_pkg::result_t               head;
    logic [sed_pkg::FIFO_CNT_W-1:0] fifo_count;
    logic                           pop;
    logic [sed_pkg::OCC_W-1:0]      occupancy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= sed_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= sed_pkg::FRAME_HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                sed_pkg::CFG_FRAME_WIDTH:
                begin
                    frame_width_reg <= cfg_data[sed_pkg::FRAME_WIDTH_W-1:0];
                end
                sed_pkg::CFG_FRAME_HEIGHT:
                begin
                    frame_height_reg <= cfg_data[sed_pkg::FRAME_HEIGHT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        w_raw = CW'(frame_width_reg);
        if (w_raw == '0)
        begin
            w_eff = CW'(1);
        end
        else if (w_raw > CW'(MAX_WIDTH))
        begin
            w_eff = CW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = w_raw;
        end
        h_eff     = (frame_height_reg == '0) ? sed_pkg::FRAME_HEIGHT_W'(1) : frame_height_reg;
        drain_row = row_reg >= {1'b0, h_eff};
        last_col  = (CW'(col_reg) + CW'(1)) >= w_eff;
        row0      = row_reg == '0;
        col0      = col_reg == '0;
        px_in     = (drain || drain_row) ? '0 : pixel;

        emit_in.emit_a      = !row0 && !col0;
        emit_in.emit_b      = !row0 && last_col;
        emit_in.run_end_a   = !last_col;
        emit_in.frame_end_b = drain_row;

        if (last_col)
        begin
            col_next = '0;
            row_next = drain_row ? '0 : (row_reg + sed_pkg::ROW_W'(1));
        end
        else
        begin
            col_next = col_reg + COL_W'(1);
            row_next = row_reg;
        end
    end

    assign accept = in_valid && !in_stall;

    // Columns are always written in order from zero, so the written entries form a prefix.
    always_comb
    begin
        fill_next = fill_reg;
        if (s1_valid_reg && ({1'b0, s1_col_reg} >= fill_reg))
        begin
            fill_next = {1'b0, s1_col_reg} + FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            fill_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= '0;
            w_emit_reg   <= '0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            fill_reg     <= fill_next;
            s1_valid_reg <= accept;
            s1_emit_reg  <= accept ? emit_in : '0;
            w_emit_reg   <= s1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg   <= col_reg;
            s1_px_reg    <= px_in;
            s1_row0_reg  <= row0;
            s1_col0_reg  <= col0;
            rd_zero_reg  <= {1'b0, col_reg} >= fill_reg;
            fwd_hit_reg  <= s1_valid_reg && (s1_col_reg == col_reg);
            fwd_word_reg <= wr_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            line_mem[s1_col_reg] <= wr_word;
        end
        if (accept)
        begin
            rd_word_reg <= line_mem[col_reg];
        end
    end

    always_comb
    begin
        if (fwd_hit_reg)
        begin
            rd_word = fwd_word_reg;
        end
        else if (rd_zero_reg)
        begin
            rd_word = '0;
        end
        else
        begin
            rd_word = rd_word_reg;
        end
        up_rd   = s1_row0_reg ? '0 : rd_word[WORD_W-1:sed_pkg::PIX_W];
        mid_rd  = s1_row0_reg ? '0 : rd_word[sed_pkg::PIX_W-1:0];
        wr_word = {mid_rd, s1_px_reg};

        window_next = window_reg;
        for (int r = 0; r < 3; r++)
        begin
            window_next[r][0] = s1_col0_reg ? '0 : window_reg[r][1];
            window_next[r][1] = s1_col0_reg ? '0 : window_reg[r][2];
        end
        window_next[0][2] = up_rd;
        window_next[1][2] = mid_rd;
        window_next[2][2] = s1_px_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            window_reg <= window_next;
        end
    end

    sed_sobel u_sobel (
        .clk    (clk),
        .rst_n  (rst_n),
        .window (window_reg),
        .emit   (w_emit_reg),
        .push_a (push_a),
        .push_b (push_b),
        .res_a  (res_a),
        .res_b  (res_b),
        .pend   (pend_sum)
    );

    sed_result_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push_a (push_a),
        .push_b (push_b),
        .res_a  (res_a),
        .res_b  (res_b),
        .pop    (pop),
        .head   (head),
        .count  (fifo_count)
    );

    // Reserve room for every result still in the pipe plus two for the next beat.
    assign occupancy = sed_pkg::OCC_W'(fifo_count)
                       + sed_pkg::OCC_W'(sed_pkg::emit_count(s1_emit_reg))
                       + sed_pkg::OCC_W'(sed_pkg::emit_count(w_emit_reg))
                       + sed_pkg::OCC_W'(pend_sum)
                       + sed_pkg::OCC_W'(2);
    assign in_stall  = occupancy > sed_pkg::OCC_W'(sed_pkg::FIFO_DEPTH);

    assign out_valid = fifo_count != '0;
    assign pop       = out_valid && !out_stall;
    assign magnitude = head.magnitude;
    assign run_end   = head.run_end;
    assign frame_end = head.frame_end;

endmodule

[hw/rtl/sed_sobel.sv]
module sed_sobel (
    input  logic             clk,
    input  logic             rst_n,
    input  sed_pkg::window_t window,
    input  sed_pkg::emit_t   emit,
    output logic             push_a,
    output logic             push_b,
    output sed_pkg::result_t res_a,
    output sed_pkg::result_t res_b,
    output logic [1:0]       pend
);

    sed_pkg::emit_t emit_reg;

    logic [sed_pkg::SUM_W-1:0] ax_l_reg;
    logic [sed_pkg::SUM_W-1:0] ax_r_reg;
    logic [sed_pkg::SUM_W-1:0] ay_t_reg;
    logic [sed_pkg::SUM_W-1:0] ay_b_reg;
    logic [sed_pkg::SUM_W-1:0] bx_l_reg;
    logic [sed_pkg::SUM_W-1:0] by_t_reg;
    logic [sed_pkg::SUM_W-1:0] by_b_reg;

    logic [sed_pkg::SUM_W-1:0] a_gx;
    logic [sed_pkg::SUM_W-1:0] a_gy;
    logic [sed_pkg::SUM_W-1:0] b_gy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_reg <= '0;
        end
        else
        begin
            emit_reg <= emit;
        end
    end

    // Weighted column and row sums; the second result sees a zero column on the right.
    always_ff @(posedge clk)
    begin
        ax_l_reg <= sed_pkg::wsum3(window[0][0], window[1][0], window[2][0]);
        ax_r_reg <= sed_pkg::wsum3(window[0][2], window[1][2], window[2][2]);
        ay_t_reg <= sed_pkg::wsum3(window[0][0], window[0][1], window[0][2]);
        ay_b_reg <= sed_pkg::wsum3(window[2][0], window[2][1], window[2][2]);
        bx_l_reg <= sed_pkg::wsum3(window[0][1], window[1][1], window[2][1]);
        by_t_reg <= sed_pkg::wsum3(window[0][1], window[0][2], '0);
        by_b_reg <= sed_pkg::wsum3(window[2][1], window[2][2], '0);
    end

    assign a_gx = sed_pkg::absdiff(ax_r_reg, ax_l_reg);
    assign a_gy = sed_pkg::absdiff(ay_b_reg, ay_t_reg);
    assign b_gy = sed_pkg::absdiff(by_b_reg, by_t_reg);

    always_comb
    begin
        res_a.magnitude = {1'b0, a_gx} + {1'b0, a_gy};
        res_a.run_end   = emit_reg.run_end_a;
        res_a.frame_end = 1'b0;
        res_b.magnitude = {1'b0, bx_l_reg} + {1'b0, b_gy};
        res_b.run_end   = 1'b1;
        res_b.frame_end = emit_reg.frame_end_b;
    end

    assign push_a = emit_reg.emit_a;
    assign push_b = emit_reg.emit_b;
    assign pend   = sed_pkg::emit_count(emit_reg);

endmodule

[hw/rtl/sed_result_fifo.sv]
module sed_result_fifo (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push_a,
    input  logic                              push_b,
    input  sed_pkg::result_t                  res_a,
    input  sed_pkg::result_t                  res_b,
    input  logic                              pop,
    output sed_pkg::result_t                  head,
    output logic [sed_pkg::FIFO_CNT_W-1:0]    count
);

    sed_pkg::result_t entry_reg [sed_pkg::FIFO_DEPTH];

    logic [sed_pkg::FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [sed_pkg::FIFO_PTR_W-1:0] wr_ptr_next;
    logic [sed_pkg::FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [sed_pkg::FIFO_PTR_W-1:0] rd_ptr_next;
    logic [sed_pkg::FIFO_CNT_W-1:0] count_reg;
    logic [sed_pkg::FIFO_CNT_W-1:0] count_next;
    logic [sed_pkg::FIFO_PTR_W-1:0] b_slot;

    // When both results of a pixel arrive together, the second goes one slot later.
    assign b_slot = push_a ? (wr_ptr_reg + sed_pkg::FIFO_PTR_W'(1)) : wr_ptr_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + sed_pkg::FIFO_PTR_W'(push_a) + sed_pkg::FIFO_PTR_W'(push_b);
        rd_ptr_next = rd_ptr_reg + sed_pkg::FIFO_PTR_W'(pop);
        count_next  = count_reg + sed_pkg::FIFO_CNT_W'(push_a) + sed_pkg::FIFO_CNT_W'(push_b)
                      - sed_pkg::FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_a)
        begin
            entry_reg[wr_ptr_reg] <= res_a;
        end
        if (push_b)
        begin
            entry_reg[b_slot] <= res_b;
        end
    end

    assign head  = entry_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule
